>>> sv/ncrb_pkg.sv
// Shared types, constants and codes for the Newton z^3-1 basin pixel engine.
// Used by the controller, the datapath, the divider, the top level and the checker.
package ncrb_pkg;

  localparam int COORD_W = 12;
  localparam int CNT_W   = 10;
  localparam int ZW      = 32;
  localparam int MW      = 34;
  localparam int PW      = 2 * MW;
  localparam int FRAC    = 28;
  localparam int NUM_W   = 36;
  localparam int DEN_W   = 37;
  localparam int DIV_QW  = 34;
  localparam int DIST_W  = 66;
  localparam int PALETTE_ENTRIES = 256;
  localparam int COLOR_W = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_X_ORIGIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_TOP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_X_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 3'd4;

  localparam logic signed [ZW-1:0] X_ORIGIN_RST = -32'sd536870912;
  localparam logic signed [ZW-1:0] Y_TOP_RST    = 32'sd536870912;
  localparam logic [30:0]          STEP_RST     = 31'd524288;
  localparam logic [CNT_W-1:0]     MAX_ITER_RST = 10'd32;

  localparam logic signed [PW-1:0]     Q_ONE     = 68'sd268435456;
  localparam logic signed [MW-1:0]     ROOT_IM   = 34'sd232471924;
  localparam logic signed [DIST_W-1:0] ONE_Q56   = 66'sd1 <<< 56;
  localparam logic signed [DIST_W-1:0] R1_SQ     =
    (66'sd1 <<< 54) + DIST_W'(ROOT_IM) * DIST_W'(ROOT_IM);
  localparam logic signed [DIST_W-1:0] CONV_LIM  = 66'sd720575940;
  localparam logic [63:0]              BOUND_Q56 = 64'h0400_0000_0000_0000;
  localparam logic signed [NUM_W-1:0]  NUM_CLAMP = 36'sd34091302912;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_col;
    logic [COORD_W-1:0] pixel_row;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] out_col;
    logic [COORD_W-1:0] out_row;
    logic               converged;
    logic [1:0]         root_found;
    logic [CNT_W-1:0]   iteration_count;
    logic [COLOR_W-1:0] palette_idx;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_INIT_X, OP_INIT_Y, OP_ZR2, OP_ZI2, OP_ZIS, OP_ZRZI,
    OP_Z2R_ZR, OP_Z2I_ZI, OP_Z2R_ZI, OP_Z2I_ZR,
    OP_DR2, OP_DI2, OP_NR_DR, OP_NI_DI, OP_NI_DR, OP_NR_DI
  } mul_op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_INIT, ST_INIT_W, ST_ZSQ, ST_CHECK, ST_POLY,
    ST_TAIL, ST_DEN, ST_DIV, ST_DONE
  } state_t;

  typedef struct packed {
    logic    load;
    logic    mul_en;
    mul_op_t mul_op;
    logic    cnt_inc;
    logic    conv_set;
    logic    div_start;
    logic    z_update;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_of_bounds;
    logic conv_hit;
    logic iter_done;
    logic den_zero;
    logic div_busy;
  } dp_status_t;

endpackage

>>> sv/ncrb_div.sv
// Restoring divider, one quotient bit per cycle, with early overflow detection.
// Depends on ncrb_pkg.
module ncrb_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [ncrb_pkg::NUM_W-1:0] num,
  input  logic [ncrb_pkg::DEN_W-1:0]       den,
  output logic                             busy,
  output logic                             ovf,
  output logic                             neg,
  output logic [ncrb_pkg::DIV_QW-1:0]      quo
);
  import ncrb_pkg::*;

  localparam int CW = $clog2(DIV_QW + 1);
  localparam int DVD_W = NUM_W - 1 + FRAC;

  logic                  busy_r, busy_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [DEN_W-1:0]      rem_r, rem_nxt;
  logic [DIV_QW-1:0]     quo_r, quo_nxt;
  logic                  ovf_r, ovf_nxt;
  logic                  neg_r, neg_nxt;
  logic [NUM_W-1:0]      mag;
  logic [DVD_W-1:0]      dvd;
  logic [DEN_W:0]        shifted;
  logic                  fits;

  always_comb begin
    mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    dvd = {mag[NUM_W-2:0], {FRAC{1'b0}}};
    shifted = {rem_r, quo_r[DIV_QW-1]};
    fits = shifted >= {1'b0, den};
    busy_nxt = busy_r;
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    ovf_nxt = ovf_r;
    neg_nxt = neg_r;
    if (start) begin
      neg_nxt = num[NUM_W-1];
      ovf_nxt = {7'b0, mag} >= {den, 6'b0};
      rem_nxt = DEN_W'(dvd[DVD_W-1:DIV_QW]);
      quo_nxt = dvd[DIV_QW-1:0];
      cnt_nxt = CW'(DIV_QW);
      busy_nxt = !ovf_nxt;
    end else if (busy_r) begin
      rem_nxt = fits ? DEN_W'(shifted - {1'b0, den}) : shifted[DEN_W-1:0];
      quo_nxt = {quo_r[DIV_QW-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      busy_nxt = cnt_r != CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    ovf_r <= ovf_nxt;
    neg_r <= neg_nxt;
  end

  assign busy = busy_r;
  assign ovf  = ovf_r;
  assign neg  = neg_r;
  assign quo  = quo_r;

endmodule

>>> sv/ncrb_dp.sv
// Datapath: configuration registers, shared multiplier, Newton step registers, dividers.
// Depends on ncrb_pkg and ncrb_div.
module ncrb_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ncrb_pkg::ctrl_cmd_t                 cmd,
  input  ncrb_pkg::in_item_t                  in_item,
  input  logic                                cfg_we,
  input  logic [ncrb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ncrb_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output ncrb_pkg::dp_status_t                status,
  output ncrb_pkg::out_item_t                 out_item
);
  import ncrb_pkg::*;

  function automatic logic signed [ZW-1:0] sat32(input logic signed [47:0] v);
    logic signed [ZW-1:0] r;
    if (v > 48'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (v < -48'sd2147483648) r = 32'sh8000_0000;
    else r = v[ZW-1:0];
    return r;
  endfunction

  function automatic logic signed [NUM_W-1:0] clamp_num(input logic signed [PW-1:0] v);
    logic signed [NUM_W-1:0] r;
    if (v > PW'(NUM_CLAMP)) r = NUM_CLAMP;
    else if (v < -PW'(NUM_CLAMP)) r = -NUM_CLAMP;
    else r = v[NUM_W-1:0];
    return r;
  endfunction

  function automatic logic signed [ZW-1:0] z_step(input logic signed [ZW-1:0] z,
                                                 input logic ovf, input logic neg,
                                                 input logic [DIV_QW-1:0] q);
    logic signed [DIV_QW:0] qs;
    logic signed [47:0]     diff;
    logic signed [ZW-1:0]   r;
    qs = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    diff = 48'(z) - 48'(qs);
    if (ovf) r = neg ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    else r = sat32(diff);
    return r;
  endfunction

  logic signed [ZW-1:0]    x_origin_r, y_top_r;
  logic [30:0]             x_step_r, y_step_r;
  logic [CNT_W-1:0]        max_iter_r;

  logic [COORD_W-1:0]      col_r, row_r;
  logic signed [ZW-1:0]    zr_r, zi_r;
  logic signed [PW-1:0]    prod_r, zr2_r, zis_r, t_a_r;
  logic [63:0]             mag_r;
  logic signed [MW-1:0]    z2r_r, z2i_r, nr_r, ni_r, dr_r, di_r;
  logic [DEN_W-1:0]        den2_r;
  logic signed [NUM_W-1:0] pr_r, pi_r;
  logic [CNT_W-1:0]        count_r;
  logic                    conv_r;
  logic [1:0]              root_r;
  logic                    wr_en_r;
  mul_op_t                 wr_op_r;

  logic signed [MW-1:0]     mul_a, mul_b;
  logic signed [DIST_W-1:0] dist0, dist_c, dist1, dist2;
  logic                     hit0, hit1, hit2;
  logic [1:0]               root_sel;
  logic                     busy_x, busy_y, ovf_x, ovf_y, neg_x, neg_y;
  logic [DIV_QW-1:0]        quo_x, quo_y;
  logic [11:0]              color_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_origin_r <= X_ORIGIN_RST;
      y_top_r    <= Y_TOP_RST;
      x_step_r   <= STEP_RST;
      y_step_r   <= STEP_RST;
      max_iter_r <= MAX_ITER_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_X_ORIGIN: x_origin_r <= $signed(cfg_wdata);
        CFG_Y_TOP:    y_top_r    <= $signed(cfg_wdata);
        CFG_X_STEP:   x_step_r   <= cfg_wdata[30:0];
        CFG_Y_STEP:   y_step_r   <= cfg_wdata[30:0];
        CFG_MAX_ITER: max_iter_r <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cmd.mul_op)
      OP_INIT_X: begin
        mul_a = $signed({3'b0, x_step_r});
        mul_b = $signed({{(MW-COORD_W){1'b0}}, col_r});
      end
      OP_INIT_Y: begin
        mul_a = $signed({3'b0, y_step_r});
        mul_b = $signed({{(MW-COORD_W){1'b0}}, row_r});
      end
      OP_ZR2:    begin mul_a = MW'(zr_r); mul_b = MW'(zr_r); end
      OP_ZI2:    begin mul_a = MW'(zi_r); mul_b = MW'(zi_r); end
      OP_ZIS:    begin mul_a = MW'(zi_r); mul_b = ROOT_IM;   end
      OP_ZRZI:   begin mul_a = MW'(zr_r); mul_b = MW'(zi_r); end
      OP_Z2R_ZR: begin mul_a = z2r_r;     mul_b = MW'(zr_r); end
      OP_Z2I_ZI: begin mul_a = z2i_r;     mul_b = MW'(zi_r); end
      OP_Z2R_ZI: begin mul_a = z2r_r;     mul_b = MW'(zi_r); end
      OP_Z2I_ZR: begin mul_a = z2i_r;     mul_b = MW'(zr_r); end
      OP_DR2:    begin mul_a = dr_r;      mul_b = dr_r;      end
      OP_DI2:    begin mul_a = di_r;      mul_b = di_r;      end
      OP_NR_DR:  begin mul_a = nr_r;      mul_b = dr_r;      end
      OP_NI_DI:  begin mul_a = ni_r;      mul_b = di_r;      end
      OP_NI_DR:  begin mul_a = ni_r;      mul_b = dr_r;      end
      OP_NR_DI:  begin mul_a = nr_r;      mul_b = di_r;      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_en_r <= 1'b0;
      count_r <= '0;
      conv_r  <= 1'b0;
      root_r  <= '0;
    end else begin
      wr_en_r <= cmd.mul_en;
      if (cmd.load) begin
        count_r <= '0;
        conv_r  <= 1'b0;
        root_r  <= '0;
      end else begin
        if (cmd.cnt_inc) count_r <= count_r + 1'b1;
        if (cmd.conv_set) begin
          conv_r <= 1'b1;
          root_r <= root_sel;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    wr_op_r <= cmd.mul_op;
    prod_r  <= mul_a * mul_b;
    if (cmd.load) begin
      col_r <= in_item.pixel_col;
      row_r <= in_item.pixel_row;
    end
    if (cmd.z_update) begin
      zr_r <= z_step(zr_r, ovf_x, neg_x, quo_x);
      zi_r <= z_step(zi_r, ovf_y, neg_y, quo_y);
    end
    if (wr_en_r) begin
      unique case (wr_op_r)
        OP_INIT_X: zr_r <= sat32(48'(x_origin_r) + $signed({1'b0, prod_r[46:0]}));
        OP_INIT_Y: zi_r <= sat32(48'(y_top_r) - $signed({1'b0, prod_r[46:0]}));
        OP_ZR2:    zr2_r <= prod_r;
        OP_ZI2: begin
          z2r_r <= MW'((zr2_r - prod_r) >>> FRAC);
          mag_r <= 64'(zr2_r + prod_r);
        end
        OP_ZIS:    zis_r <= prod_r;
        OP_ZRZI:   z2i_r <= MW'(prod_r >>> (FRAC - 1));
        OP_Z2R_ZR: t_a_r <= prod_r;
        OP_Z2I_ZI: begin
          nr_r <= MW'(((t_a_r - prod_r) >>> FRAC) - Q_ONE);
          dr_r <= z2r_r + (z2r_r <<< 1);
          di_r <= z2i_r + (z2i_r <<< 1);
        end
        OP_Z2R_ZI: t_a_r <= prod_r;
        OP_Z2I_ZR: ni_r <= MW'((t_a_r + prod_r) >>> FRAC);
        OP_DR2:    t_a_r <= prod_r;
        OP_DI2:    den2_r <= DEN_W'(prod_r[PW-1:FRAC] + t_a_r[PW-1:FRAC]);
        OP_NR_DR:  t_a_r <= prod_r;
        OP_NI_DI:  pr_r <= clamp_num((t_a_r >>> FRAC) + (prod_r >>> FRAC));
        OP_NI_DR:  t_a_r <= prod_r;
        OP_NR_DI:  pi_r <= clamp_num((t_a_r >>> FRAC) - (prod_r >>> FRAC));
      endcase
    end
  end

  // Squared distances to the roots, expanded so that only zi*sqrt(3)/2 needs a product.
  always_comb begin
    dist0  = $signed({2'b0, mag_r}) + ONE_Q56 - (DIST_W'(zr_r) <<< (FRAC + 1));
    dist_c = $signed({2'b0, mag_r}) + (DIST_W'(zr_r) <<< FRAC) + R1_SQ;
    dist1  = dist_c - (DIST_W'(zis_r) <<< 1);
    dist2  = dist_c + (DIST_W'(zis_r) <<< 1);
    hit0 = dist0 <= CONV_LIM;
    hit1 = dist1 <= CONV_LIM;
    hit2 = dist2 <= CONV_LIM;
    priority if (hit0) root_sel = 2'd0;
    else if (hit1)     root_sel = 2'd1;
    else               root_sel = 2'd2;
  end

  ncrb_div u_div_x (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .num(pr_r), .den(den2_r),
    .busy(busy_x), .ovf(ovf_x), .neg(neg_x), .quo(quo_x)
  );

  ncrb_div u_div_y (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .num(pi_r), .den(den2_r),
    .busy(busy_y), .ovf(ovf_y), .neg(neg_y), .quo(quo_y)
  );

  always_comb begin
    status.out_of_bounds = mag_r > BOUND_Q56;
    status.conv_hit      = hit0 || hit1 || hit2;
    status.iter_done     = count_r == max_iter_r;
    status.den_zero      = den2_r == '0;
    status.div_busy      = busy_x || busy_y;
    color_sum = 12'(root_r) * 12'd5 + 12'(count_r);
    out_item.out_col         = col_r;
    out_item.out_row         = row_r;
    out_item.converged       = conv_r;
    out_item.root_found      = conv_r ? root_r : 2'd0;
    out_item.iteration_count = count_r;
    out_item.palette_idx     = conv_r ? COLOR_W'(color_sum % PALETTE_ENTRIES) : '0;
  end

endmodule

>>> sv/ncrb_ctrl.sv
// Controller state machine sequencing the shared multiplier, checks and dividers.
// Depends on ncrb_pkg.
module ncrb_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  ncrb_pkg::dp_status_t status,
  output ncrb_pkg::ctrl_cmd_t  cmd,
  output logic                 busy,
  output logic                 out_valid
);
  import ncrb_pkg::*;

  state_t  state_r, state_nxt;
  mul_op_t uop_r, uop_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      uop_r   <= OP_INIT_X;
    end else begin
      state_r <= state_nxt;
      uop_r   <= uop_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    uop_nxt = uop_r;
    unique case (state_r)
      ST_IDLE: begin
        uop_nxt = OP_INIT_X;
        if (start) state_nxt = ST_INIT;
      end
      ST_INIT: begin
        uop_nxt = mul_op_t'(uop_r + 4'd1);
        if (uop_r == OP_INIT_Y) state_nxt = ST_INIT_W;
      end
      ST_INIT_W: begin
        uop_nxt = OP_ZR2;
        state_nxt = status.iter_done ? ST_DONE : ST_ZSQ;
      end
      ST_ZSQ: begin
        uop_nxt = mul_op_t'(uop_r + 4'd1);
        if (uop_r == OP_ZRZI) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        uop_nxt = OP_Z2R_ZR;
        if (status.out_of_bounds || status.conv_hit) state_nxt = ST_DONE;
        else state_nxt = ST_POLY;
      end
      ST_POLY: begin
        uop_nxt = mul_op_t'(uop_r + 4'd1);
        if (uop_r == OP_NR_DI) state_nxt = ST_TAIL;
      end
      ST_TAIL: state_nxt = ST_DEN;
      ST_DEN:  state_nxt = status.den_zero ? ST_DONE : ST_DIV;
      ST_DIV: begin
        uop_nxt = OP_ZR2;
        if (!status.div_busy) state_nxt = status.iter_done ? ST_DONE : ST_ZSQ;
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.mul_op = uop_r;
    busy = state_r != ST_IDLE;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE:  cmd.load = start;
      ST_INIT:  cmd.mul_en = 1'b1;
      ST_INIT_W: ;
      ST_ZSQ:   cmd.mul_en = 1'b1;
      ST_CHECK: begin
        cmd.conv_set = !status.out_of_bounds && status.conv_hit;
        cmd.cnt_inc  = !status.out_of_bounds && !status.conv_hit;
      end
      ST_POLY:  cmd.mul_en = 1'b1;
      ST_TAIL: ;
      ST_DEN:   cmd.div_start = !status.den_zero;
      ST_DIV:   cmd.z_update = !status.div_busy;
      ST_DONE:  out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule

>>> sv/newton_cubic_root_basin_pixel.sv
// Newton basin engine for z^3-1, one pixel at a time in Q4.28 fixed point. A pixel is
// taken when start is high and busy is low; its result appears for one cycle with
// out_valid and must be captured then, since the engine cannot be held off. Each Newton
// step uses the shared 34x34 multiplier, the bit-serial dividers that run the real and
// imaginary quotients side by side, and the checks. A pixel that stops early ends at its
// bound or convergence test or at a zero derivative. The default limit is 32 Newton steps.
// Configuration is written through cfg_we, cfg_index and cfg_wdata; the user must write
// it only while the engine is idle, since the block itself does not enforce this.
module newton_cubic_root_basin_pixel (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  ncrb_pkg::in_item_t              in_item,
  output logic                            out_valid,
  output ncrb_pkg::out_item_t             out_item,
  input  logic                            cfg_we,
  input  logic [ncrb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ncrb_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ncrb_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  ncrb_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .status(status), .cmd(cmd),
    .busy(busy), .out_valid(out_valid)
  );

  ncrb_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_item(in_item), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata), .status(status), .out_item(out_item)
  );

endmodule

>>> sv/ncrb_chk.sv
// Port-level checker for the Newton basin engine, bound to the top level.
// Depends on ncrb_pkg.
module ncrb_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input ncrb_pkg::out_item_t out_item
);
  import ncrb_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted transfer did not raise busy");

  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result shown while idle");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy && !out_valid) else $error("engine did not return to idle");

  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.converged |-> out_item.palette_idx == '0 &&
    out_item.root_found == 2'd0) else $error("unconverged pixel carries a color");

endmodule

bind newton_cubic_root_basin_pixel ncrb_chk u_chk (.*);

>>> verif/ncrb_checker.sv
`timescale 1ns / 100ps
// Checker for the Newton z^3-1 basin pixel engine: it watches the configuration port and
// both transfer channels, predicts each pixel in Q4.28 and compares every result.
// Depends on ncrb_pkg for the item types, the register codes and the reset values.
module ncrb_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic                            busy,
  input  ncrb_pkg::in_item_t              in_item,
  input  logic                            out_valid,
  input  ncrb_pkg::out_item_t             out_item,
  input  logic                            cfg_we,
  input  logic [ncrb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ncrb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              fail_count,
  output int                              pending_count
);
  import ncrb_pkg::*;

  localparam longint ONE_Q28  = 64'sd268435456;
  localparam longint HALF_Q28 = 64'sd134217728;
  localparam longint SQRT3_2  = 64'sd232471924;
  localparam longint CONV_Q56 = 64'sd720575940;
  localparam longint CLAMP_Q  = 64'sd127 * 64'sd268435456;

  logic signed [31:0] x_origin_r, y_top_r;
  logic [30:0]        x_step_r, y_step_r;
  logic [9:0]         max_iter_r;
  out_item_t          expected_pixels[$];

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clamp_num(longint v);
    if (v > CLAMP_Q) return CLAMP_Q;
    if (v < -CLAMP_Q) return -CLAMP_Q;
    return v;
  endfunction

  function automatic longint unsigned square_mag(longint v);
    longint unsigned m;
    m = (v < 0) ? longint'(-v) : longint'(v);
    return m * m;
  endfunction

  function automatic out_item_t basin_of(in_item_t px);
    out_item_t r;
    longint zr, zi, zr2, zi2, z2r, z2i, z3r, z3i, nr, ni, dr, di, den2, pr, pi, a, b;
    longint rre[3], rim[3];
    int unsigned cnt, rt;
    bit conv, stop;
    rre[0] = ONE_Q28;   rim[0] = 0;
    rre[1] = -HALF_Q28; rim[1] = SQRT3_2;
    rre[2] = -HALF_Q28; rim[2] = -SQRT3_2;
    zr = sat32(longint'(x_origin_r) + longint'(px.pixel_col) * longint'(x_step_r));
    zi = sat32(longint'(y_top_r) - longint'(px.pixel_row) * longint'(y_step_r));
    cnt = 0; rt = 0; conv = 0; stop = 0;
    for (int it = 0; it < max_iter_r && !stop; it++) begin
      zr2 = zr * zr;
      zi2 = zi * zi;
      if (unsigned'(zr2) + unsigned'(zi2) > (64'd4 << 56)) begin
        stop = 1;
      end else begin
        for (int k = 0; k < 3 && !conv; k++) begin
          a = zr - rre[k];
          b = zi - rim[k];
          if (a * a + b * b <= CONV_Q56) begin
            conv = 1;
            rt = k;
          end
        end
        if (conv) begin
          stop = 1;
        end else begin
          cnt++;
          z2r = (zr2 - zi2) >>> 28;
          z2i = (2 * zr * zi) >>> 28;
          z3r = (z2r * zr - z2i * zi) >>> 28;
          z3i = (z2r * zi + z2i * zr) >>> 28;
          nr = z3r - ONE_Q28;
          ni = z3i;
          dr = 3 * z2r;
          di = 3 * z2i;
          den2 = longint'((square_mag(dr) >> 28) + (square_mag(di) >> 28));
          if (den2 == 0) begin
            stop = 1;
          end else begin
            pr = clamp_num(((nr * dr) >>> 28) + ((ni * di) >>> 28));
            pi = clamp_num(((ni * dr) >>> 28) - ((nr * di) >>> 28));
            zr = sat32(zr - (pr * ONE_Q28) / den2);
            zi = sat32(zi - (pi * ONE_Q28) / den2);
          end
        end
      end
    end
    r.out_col         = px.pixel_col;
    r.out_row         = px.pixel_row;
    r.converged       = conv;
    r.root_found      = conv ? rt[1:0] : 2'd0;
    r.iteration_count = cnt[9:0];
    r.palette_idx     = conv ? 8'((rt * 5 + cnt) % PALETTE_ENTRIES) : 8'd0;
    return r;
  endfunction

  assign pending_count = expected_pixels.size();

  always @(posedge clk) begin
    out_item_t exp_px;
    if (!rst_n) begin
      x_origin_r <= X_ORIGIN_RST;
      y_top_r    <= Y_TOP_RST;
      x_step_r   <= STEP_RST;
      y_step_r   <= STEP_RST;
      max_iter_r <= MAX_ITER_RST;
      fail_count <= 0;
      expected_pixels.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_X_ORIGIN: x_origin_r <= cfg_wdata;
          CFG_Y_TOP:    y_top_r    <= cfg_wdata;
          CFG_X_STEP:   x_step_r   <= cfg_wdata[30:0];
          CFG_Y_STEP:   y_step_r   <= cfg_wdata[30:0];
          CFG_MAX_ITER: max_iter_r <= cfg_wdata[9:0];
          default: ;
        endcase
      end
      if (start && !busy) expected_pixels.push_back(basin_of(in_item));
      if (out_valid) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, out_item);
          fail_count <= fail_count + 1;
        end else begin
          exp_px = expected_pixels.pop_front();
          if (out_item !== exp_px) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, exp_px, out_item);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// Top of the Newton z^3-1 basin pixel testbench: clock, reset, register setup and pixel
// stimulus, with ncrb_checker beside the engine. Depends on ncrb_pkg and the engine RTL.
module tb_top;
  import ncrb_pkg::*;

  logic                  clk, rst_n, start, busy, out_valid, cfg_we;
  in_item_t              in_item;
  out_item_t             out_item;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count, pending_count;
  int                    gap_pct;

  newton_cubic_root_basin_pixel uut (.*);
  ncrb_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("[newton_cubic_root_basin_pixel] ERROR");
    $finish;
  end

  task automatic send_pixel(int col, int row);
    while ($urandom_range(99) < gap_pct) begin
      start = 0;
      @(negedge clk);
    end
    start = 1;
    in_item.pixel_col = col[11:0];
    in_item.pixel_row = row[11:0];
    do @(posedge clk); while (busy);
    @(negedge clk);
    start = 0;
  endtask

  task automatic drain();
    while (pending_count != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we = 1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic set_view(int xo, int yt, int xs, int ys, int iters);
    drain();
    write_reg(CFG_X_ORIGIN, xo);
    write_reg(CFG_Y_TOP, yt);
    write_reg(CFG_X_STEP, xs);
    write_reg(CFG_Y_STEP, ys);
    write_reg(CFG_MAX_ITER, iters);
  endtask

  initial begin
    rst_n = 0; start = 0; cfg_we = 0; cfg_index = '0; cfg_wdata = '0;
    in_item = '0; gap_pct = 0;
    repeat (3) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // Exact roots, the origin with its zero derivative, and the image corners.
    send_pixel(1536, 1024);
    send_pixel(768, 581);
    send_pixel(768, 1467);
    send_pixel(1024, 1024);
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(0, 4095);
    send_pixel(4095, 0);
    send_pixel(1300, 900);
    set_view(-536870912, 536870912, 524288, 524288, 0);
    send_pixel(1536, 1024);
    send_pixel(4095, 4095);
    set_view(-536870912, 536870912, 524288, 524288, 1023);
    send_pixel(1100, 1000);
    send_pixel(1000, 1100);
    send_pixel(3000, 3000);
    // Start points that saturate and large quotients near zero.
    set_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8);
    send_pixel(4095, 4095);
    send_pixel(0, 0);
    set_view(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 8);
    send_pixel(123, 456);
    set_view(-64, 64, 1, 1, 16);
    send_pixel(64, 64);
    send_pixel(65, 63);
    send_pixel(4095, 0);

    for (int ph = 0; ph < 12; ph++) begin
      gap_pct = (ph < 4) ? 11 : (ph < 8) ? 84 : 0;
      if (ph % 4 == 3)
        set_view($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 40));
      else
        set_view(-$urandom_range(1 << 28, 3 << 28), $urandom_range(1 << 28, 3 << 28),
                 $urandom_range(1 << 15, 1 << 20), $urandom_range(1 << 15, 1 << 20),
                 $urandom_range(1, 40));
      for (int n = 0; n < 50; n++) send_pixel($urandom_range(4095), $urandom_range(4095));
    end

    drain();
    repeat (100) @(posedge clk);
    if (fail_count == 0)
      $display("[newton_cubic_root_basin_pixel] OK");
    else
      $display("[newton_cubic_root_basin_pixel] ERROR");
    $finish;
  end

endmodule

>>> files.f
sv/ncrb_pkg.sv
sv/ncrb_div.sv
sv/ncrb_dp.sv
sv/ncrb_ctrl.sv
sv/newton_cubic_root_basin_pixel.sv
sv/ncrb_chk.sv
verif/ncrb_checker.sv
verif/tb_top.sv
